[rtl/core/nppq_pkg.sv]
// Shared types, constants and codes for the nearest palette color quantizer.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package nppq_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int COLOR_W    = 8;
    localparam int IDX_W      = 8;
    localparam int SQ_W       = 2 * COLOR_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OPAQUE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSP_IDX = 2'd1;

    localparam logic [COLOR_W-1:0] OPAQUE_THR_RST = 8'd128;
    localparam logic [IDX_W-1:0]   TRANSP_IDX_RST = 8'hFF;

    // Item opcodes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUANT = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    // Control that travels with each palette entry down the search pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_scan_tag;

endpackage

[rtl/core/nppq_palette_ram.sv]
// Palette storage: one synchronous RAM with a registered read port.
// Per-entry valid bits make entries read as black until they are loaded.
// Depends on nppq_pkg.
module nppq_palette_ram #(
    parameter int DEPTH  = nppq_pkg::PALETTE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  nppq_pkg::t_rgb      i_wdata,
    input  logic [ADDR_W-1:0]   i_raddr,
    output nppq_pkg::t_rgb      o_rdata
);

    nppq_pkg::t_rgb    mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    nppq_pkg::t_rgb    r_rdata;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    // An entry that was never loaded reads as zero.
    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

[rtl/core/nppq_dist_unit.sv]
// Per-channel squared difference stage of the palette search pipeline.
// Registers the three squares together with the entry tag. Depends on nppq_pkg.
module nppq_dist_unit #(
    parameter int ADDR_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nppq_pkg::t_rgb              i_pixel,
    input  nppq_pkg::t_rgb              i_entry,
    input  nppq_pkg::t_scan_tag         i_tag,
    input  logic [ADDR_W-1:0]           i_idx,
    output nppq_pkg::t_scan_tag         o_tag,
    output logic [ADDR_W-1:0]           o_idx,
    output logic [nppq_pkg::SQ_W-1:0]   o_sq_red,
    output logic [nppq_pkg::SQ_W-1:0]   o_sq_green,
    output logic [nppq_pkg::SQ_W-1:0]   o_sq_blue
);

    logic [nppq_pkg::COLOR_W-1:0] d_red;
    logic [nppq_pkg::COLOR_W-1:0] d_green;
    logic [nppq_pkg::COLOR_W-1:0] d_blue;

    nppq_pkg::t_scan_tag          r_tag;
    logic [ADDR_W-1:0]            r_idx;
    logic [nppq_pkg::SQ_W-1:0]    r_sq_red;
    logic [nppq_pkg::SQ_W-1:0]    r_sq_green;
    logic [nppq_pkg::SQ_W-1:0]    r_sq_blue;

    always_comb begin
        d_red   = (i_pixel.red   > i_entry.red)   ? i_pixel.red   - i_entry.red
                                                  : i_entry.red   - i_pixel.red;
        d_green = (i_pixel.green > i_entry.green) ? i_pixel.green - i_entry.green
                                                  : i_entry.green - i_pixel.green;
        d_blue  = (i_pixel.blue  > i_entry.blue)  ? i_pixel.blue  - i_entry.blue
                                                  : i_entry.blue  - i_pixel.blue;
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= i_idx;
        r_sq_red   <= nppq_pkg::SQ_W'(d_red)   * nppq_pkg::SQ_W'(d_red);
        r_sq_green <= nppq_pkg::SQ_W'(d_green) * nppq_pkg::SQ_W'(d_green);
        r_sq_blue  <= nppq_pkg::SQ_W'(d_blue)  * nppq_pkg::SQ_W'(d_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    assign o_tag      = r_tag;
    assign o_idx      = r_idx;
    assign o_sq_red   = r_sq_red;
    assign o_sq_green = r_sq_green;
    assign o_sq_blue  = r_sq_blue;

endmodule

[rtl/core/nearest_palette_color_quantizer.sv]
// Top level of the nearest palette color quantizer: control sequencer, minimum
// search and output register. Depends on nppq_pkg, nppq_palette_ram and
// nppq_dist_unit.
//
// Usage:
// The input channel (i_valid / o_stall) carries one beat per item. A beat with
// opcode OP_LOAD writes red, green and blue into palette entry entry_index; an
// index at or above PALETTE_ENTRIES is dropped. A load returns no result. A
// beat with opcode OP_QUANT returns exactly one beat on the output channel
// (o_valid / i_stall) carrying palette_index.
// A pixel whose alpha is below the opaque threshold register answers the
// transparent index register, passed through the result register. An opaque
// pixel walks the palette RAM one entry per cycle through a three-stage read /
// square / compare pipeline; o_stall stays high for the whole palette scan,
// which sets the throughput. The lowest index wins among equal distances.
// The result sits in an output register, so the next item is taken while an
// earlier result waits; if the receiver still stalls when the next result is
// ready, the block holds that result and keeps o_stall high.
// Synchronous active-low reset loads the threshold with 128 and the
// transparent index with 255, and clears the per-entry valid bits so the whole
// palette reads as black at once; no clearing pass is needed. Configuration
// writes are taken whenever i_cfg_we is high and should only come while idle.
module nearest_palette_color_quantizer #(
    parameter int PALETTE_ENTRIES = nppq_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [nppq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nppq_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input item channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic [nppq_pkg::IDX_W-1:0]          i_entry_index,
    input  logic [nppq_pkg::COLOR_W-1:0]        i_red,
    input  logic [nppq_pkg::COLOR_W-1:0]        i_green,
    input  logic [nppq_pkg::COLOR_W-1:0]        i_blue,
    input  logic [nppq_pkg::COLOR_W-1:0]        i_alpha,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [nppq_pkg::IDX_W-1:0]          o_palette_index
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

    // Sequencer state codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    logic [nppq_pkg::COLOR_W-1:0]     r_opaque_thr;
    logic [nppq_pkg::IDX_W-1:0]       r_transp_idx;
    nppq_pkg::t_rgb                   r_pix;
    logic                             r_issue_on;
    logic [ADDR_W-1:0]                r_scan_addr;
    nppq_pkg::t_scan_tag              r_tag1;
    logic [ADDR_W-1:0]                r_idx1;
    logic [nppq_pkg::DIST_W-1:0]      r_best_dist;
    logic [ADDR_W-1:0]                r_best_idx;
    logic [nppq_pkg::IDX_W-1:0]       r_result;
    logic                             r_out_valid;
    logic [nppq_pkg::IDX_W-1:0]       r_out_index;

    logic                             in_accept;
    logic                             out_accept;
    logic                             out_free;
    logic                             load_we;
    nppq_pkg::t_rgb                   in_rgb;
    nppq_pkg::t_rgb                   entry_rgb;
    nppq_pkg::t_scan_tag              tag0;
    nppq_pkg::t_scan_tag              tag2;
    logic [ADDR_W-1:0]                idx2;
    logic [nppq_pkg::SQ_W-1:0]        sq_red;
    logic [nppq_pkg::SQ_W-1:0]        sq_green;
    logic [nppq_pkg::SQ_W-1:0]        sq_blue;
    logic [nppq_pkg::DIST_W-1:0]      sum_dist;
    logic                             take;
    logic [ADDR_W-1:0]                n_best_idx;

    assign o_stall    = (r_state != ST_IDLE);
    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_out_valid && !i_stall;
    assign out_free   = !r_out_valid || !i_stall;

    assign in_rgb = '{red: i_red, green: i_green, blue: i_blue};

    // Loads beyond the configured palette size are dropped.
    assign load_we = in_accept && (i_opcode == nppq_pkg::OP_LOAD)
                     && ({1'b0, i_entry_index} < 9'(PALETTE_ENTRIES));

    assign tag0 = '{valid: r_issue_on,
                    first: (r_scan_addr == '0),
                    last:  (r_scan_addr == LAST_ADDR)};

    nppq_palette_ram #(
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (load_we),
        .i_waddr (i_entry_index[ADDR_W-1:0]),
        .i_wdata (in_rgb),
        .i_raddr (r_scan_addr),
        .o_rdata (entry_rgb)
    );

    nppq_dist_unit #(
        .ADDR_W (ADDR_W)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pixel    (r_pix),
        .i_entry    (entry_rgb),
        .i_tag      (r_tag1),
        .i_idx      (r_idx1),
        .o_tag      (tag2),
        .o_idx      (idx2),
        .o_sq_red   (sq_red),
        .o_sq_green (sq_green),
        .o_sq_blue  (sq_blue)
    );

    // Final stage: sum the squares and keep the running minimum. A strict
    // less-than keeps the lowest index among equal distances.
    always_comb begin
        sum_dist = nppq_pkg::DIST_W'(sq_red) + nppq_pkg::DIST_W'(sq_green)
                   + nppq_pkg::DIST_W'(sq_blue);
        take       = tag2.valid && (tag2.first || (sum_dist < r_best_dist));
        n_best_idx = take ? idx2 : r_best_idx;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_opcode == nppq_pkg::OP_QUANT)) begin
                    n_state = (i_alpha < r_opaque_thr) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tag2.valid && tag2.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx1 <= r_scan_addr;
        if (take) begin
            r_best_dist <= sum_dist;
            r_best_idx  <= idx2;
        end
        if (in_accept) begin
            r_pix <= in_rgb;
        end
        if (r_state == ST_IDLE) begin
            r_result <= r_transp_idx;
        end else if (r_state == ST_SCAN && tag2.valid && tag2.last) begin
            r_result <= nppq_pkg::IDX_W'(n_best_idx);
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_index <= r_result;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_opaque_thr <= nppq_pkg::OPAQUE_THR_RST;
            r_transp_idx <= nppq_pkg::TRANSP_IDX_RST;
            r_issue_on   <= 1'b0;
            r_scan_addr  <= '0;
            r_tag1       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tag1  <= tag0;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    nppq_pkg::REG_OPAQUE_THR: r_opaque_thr <= i_cfg_wdata;
                    nppq_pkg::REG_TRANSP_IDX: r_transp_idx <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // Address sweep over the palette, one entry per cycle.
            if (r_state == ST_IDLE && n_state == ST_SCAN) begin
                r_issue_on  <= 1'b1;
                r_scan_addr <= '0;
            end else if (r_issue_on) begin
                if (r_scan_addr == LAST_ADDR) begin
                    r_issue_on <= 1'b0;
                end else begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                end
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_palette_index = r_out_index;

    // The sequencer leaves the scan only when the last entry has been compared.
    a_scan_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && n_state != ST_SCAN) |-> (tag2.valid && tag2.last))
        else $error("scan finished before the last palette entry was compared");

    // Addresses are only issued while a scan is in progress.
    a_issue_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue_on |-> (r_state == ST_SCAN))
        else $error("palette read issued outside a scan");

    // The last entry never sits in two pipeline stages at once.
    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_tag1.valid && r_tag1.last, tag2.valid && tag2.last}))
        else $error("more than one last-entry tag in the search pipeline");

    // A load beat never produces a result or leaves the idle state.
    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_opcode == nppq_pkg::OP_LOAD) |=> (r_state == ST_IDLE))
        else $error("load beat moved the sequencer out of idle");

endmodule

[sim/nearest_palette_color_quantizer_tb.sv]
// Self-checking testbench for the nearest palette color quantizer.
// Depends on nppq_pkg and nearest_palette_color_quantizer; a scoreboard class
// mirrors the palette and registers and predicts every pixel result.
module nearest_palette_color_quantizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES         = nppq_pkg::PALETTE_ENTRIES_DEF;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 8;
    // A load returns no result, so a few quiet cycles after the last
    // pixel result are enough before a register write.
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 300;
    localparam int HOLD_CYCLES     = 2000;
    localparam int HOLD_PIXELS     = 8;
    localparam int RANDOM_SEGMENTS = 6;
    localparam int PALETTE_BURST   = 24;
    localparam int SEGMENT_BEATS   = 292;
    localparam int LOAD_PCT        = 40;

    // Register indexes that the block does not decode; writes must be ignored.
    localparam logic [nppq_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [nppq_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // One beat on the input channel.
    typedef struct {
        logic                         opcode;
        logic [nppq_pkg::IDX_W-1:0]   entry_index;
        nppq_pkg::t_rgb               color;
        logic [nppq_pkg::COLOR_W-1:0] alpha;
    } t_quant_beat;

    // Mirror of the palette and the two registers. Every accepted input beat
    // updates the mirror or queues the index the block must answer; every
    // accepted result beat is checked against the oldest queued index.
    class t_palette_tracker;
        nppq_pkg::t_rgb               palette [ENTRIES];
        logic [nppq_pkg::COLOR_W-1:0] opaque_thr;
        logic [nppq_pkg::IDX_W-1:0]   transp_idx;
        logic [nppq_pkg::IDX_W-1:0]   expected_indexes [$];
        int                           mismatches;

        function void reset_state();
            foreach (palette[i]) palette[i] = '0;
            opaque_thr = nppq_pkg::OPAQUE_THR_RST;
            transp_idx = nppq_pkg::TRANSP_IDX_RST;
            expected_indexes.delete();
            mismatches = 0;
        endfunction

        function void write_reg(logic [nppq_pkg::CFG_IDX_W-1:0] idx,
                                logic [nppq_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                nppq_pkg::REG_OPAQUE_THR: opaque_thr = val;
                nppq_pkg::REG_TRANSP_IDX: transp_idx = val;
                default: ;
            endcase
        endfunction

        // Full scan for the least squared RGB distance; a strict compare
        // keeps the lowest index among equal distances.
        function logic [nppq_pkg::IDX_W-1:0] nearest_entry_of(nppq_pkg::t_rgb px);
            int best;
            int best_dist;
            int cur_dist;
            int dr;
            int dg;
            int db;
            best      = 0;
            best_dist = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                dr       = int'(px.red)   - int'(palette[i].red);
                dg       = int'(px.green) - int'(palette[i].green);
                db       = int'(px.blue)  - int'(palette[i].blue);
                cur_dist = dr * dr + dg * dg + db * db;
                if (i == 0 || cur_dist < best_dist) begin
                    best_dist = cur_dist;
                    best      = i;
                end
            end
            return nppq_pkg::IDX_W'(best);
        endfunction

        function void note_beat(t_quant_beat beat);
            if (beat.opcode == nppq_pkg::OP_LOAD) begin
                if (int'(beat.entry_index) < ENTRIES) palette[beat.entry_index] = beat.color;
            end else if (beat.alpha < opaque_thr) begin
                expected_indexes.insert(expected_indexes.size(), transp_idx);
            end else begin
                expected_indexes.insert(expected_indexes.size(),
                                        nearest_entry_of(beat.color));
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_index(logic [nppq_pkg::IDX_W-1:0] got);
            logic [nppq_pkg::IDX_W-1:0] want;
            if (expected_indexes.size() == 0) begin
                report_mismatch($sformatf("palette_index %0d with no pixel pending", got));
            end else begin
                want = expected_indexes.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("palette_index %0d, predicted %0d", got, want));
            end
        endtask
    endclass

    // Every input is known from time zero.
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [nppq_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [nppq_pkg::CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                            i_valid       = 1'b0;
    logic                            i_opcode      = nppq_pkg::OP_LOAD;
    logic [nppq_pkg::IDX_W-1:0]      i_entry_index = '0;
    logic [nppq_pkg::COLOR_W-1:0]    i_red         = '0;
    logic [nppq_pkg::COLOR_W-1:0]    i_green       = '0;
    logic [nppq_pkg::COLOR_W-1:0]    i_blue        = '0;
    logic [nppq_pkg::COLOR_W-1:0]    i_alpha       = '0;
    logic                            i_stall       = 1'b0;
    logic                            o_stall;
    logic                            o_valid;
    logic [nppq_pkg::IDX_W-1:0]      o_palette_index;

    // Idle chances in percent per cycle, and the long receiver hold-off.
    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 85;
    logic        hold_off      = 1'b0;

    t_palette_tracker tracker = new;

    nearest_palette_color_quantizer #(
        .PALETTE_ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_alpha        (i_alpha),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_palette_index(o_palette_index)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic t_quant_beat make_beat(logic op, logic [7:0] idx, logic [7:0] r,
                                              logic [7:0] g, logic [7:0] b, logic [7:0] a);
        t_quant_beat beat;
        beat.opcode      = op;
        beat.entry_index = idx;
        beat.color       = nppq_pkg::t_rgb'{r, g, b};
        beat.alpha       = a;
        return beat;
    endfunction

    // Moves a component a few steps, clamped to the 8-bit range, so pixels
    // land close to stored colors and the search has near ties to settle.
    function automatic logic [7:0] nudge(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // Random beat. Colors are either fresh, copies of a stored entry (which
    // makes duplicate entries and exact hits), near copies, or corners of the
    // color cube. Alpha often sits right at the threshold.
    function automatic t_quant_beat random_beat(int unsigned load_pct);
        t_quant_beat    beat;
        nppq_pkg::t_rgb base;
        beat.opcode      = ($urandom_range(99) < load_pct) ? nppq_pkg::OP_LOAD
                                                           : nppq_pkg::OP_QUANT;
        beat.entry_index = 8'($urandom_range(255));
        base             = tracker.palette[$urandom_range(ENTRIES - 1)];
        case ($urandom_range(3))
            0: beat.color = nppq_pkg::t_rgb'(24'($urandom()));
            1: beat.color = base;
            2: beat.color = nppq_pkg::t_rgb'{nudge(base.red), nudge(base.green),
                                             nudge(base.blue)};
            default: begin
                beat.color.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                beat.color.green = $urandom_range(1) ? 8'hFF : 8'h00;
                beat.color.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
        endcase
        case ($urandom_range(4))
            0: beat.alpha = tracker.opaque_thr;
            1: beat.alpha = (tracker.opaque_thr == 8'h00) ? 8'h00 : tracker.opaque_thr - 8'h01;
            2: beat.alpha = 8'hFF;
            default: beat.alpha = 8'($urandom_range(255));
        endcase
        return beat;
    endfunction

    // Offers one beat after a random idle gap and returns at the edge that
    // takes it. Valid stays high when the next beat follows without a gap,
    // so it is only ever lowered in a step where nothing is raised.
    task automatic send_item(t_quant_beat beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= beat.opcode;
        i_entry_index <= beat.entry_index;
        i_red         <= beat.color.red;
        i_green       <= beat.color.green;
        i_blue        <= beat.color.blue;
        i_alpha       <= beat.alpha;
        do @(posedge i_clk); while (o_stall);
        tracker.note_beat(beat);
    endtask

    // Stops offering beats until every pixel result has come back, then lets
    // the block settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_indexes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers while the block is idle. The undecoded indexes
    // are written with junk after each of them, which must change nothing.
    task automatic set_config(logic [7:0] thr, logic [7:0] tidx);
        logic [nppq_pkg::CFG_IDX_W-1:0]  idx_seq  [4];
        logic [nppq_pkg::CFG_DATA_W-1:0] data_seq [4];
        idx_seq  = '{nppq_pkg::REG_OPAQUE_THR, REG_SPARE_A,
                     nppq_pkg::REG_TRANSP_IDX, REG_SPARE_B};
        data_seq = '{thr, 8'($urandom_range(255)), tidx, 8'($urandom_range(255))};
        wait_idle();
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            i_cfg_index <= idx_seq[k];
            i_cfg_wdata <= data_seq[k];
            @(posedge i_clk);
            tracker.write_reg(idx_seq[k], data_seq[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side. The values read right after the edge are the ones the
    // edge saw, so a beat counts exactly when the block counted it.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) tracker.check_index(o_palette_index);
            i_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        logic [7:0] thr_val;
        logic [7:0] tidx_val;
        tracker.reset_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats under the reset register values first.
        // A cleared palette is all black: an opaque pixel ties everywhere and
        // takes entry zero.
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
        // Alpha one below the threshold is transparent, at the threshold opaque.
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h80));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'hA5, 8'h12, 8'h34, 8'h56, 8'h00));
        // The top entry alone is white.
        send_item(make_beat(nppq_pkg::OP_LOAD,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // A second white entry lower down must win the tie.
        send_item(make_beat(nppq_pkg::OP_LOAD,  8'h07, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h5A, 8'hF0, 8'hF0, 8'hF0, 8'hC3));
        // Grey 0x40 is as far from mid grey at entry zero as from black at entry one.
        send_item(make_beat(nppq_pkg::OP_LOAD,  8'h00, 8'h80, 8'h80, 8'h80, 8'h00));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'h40, 8'h40, 8'h40, 8'hFF));
        send_item(make_beat(nppq_pkg::OP_LOAD,  8'h03, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_item(make_beat(nppq_pkg::OP_LOAD,  8'h04, 8'h00, 8'hFF, 8'h00, 8'h00));
        send_item(make_beat(nppq_pkg::OP_LOAD,  8'h05, 8'h00, 8'h00, 8'hFF, 8'h00));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'hE0, 8'h20, 8'h10, 8'hFF));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'h10, 8'hD0, 8'h30, 8'hFF));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF));
        // A color one step off black, stored at a high entry.
        send_item(make_beat(nppq_pkg::OP_LOAD,  8'h80, 8'h01, 8'h00, 8'h00, 8'h00));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'h01, 8'h00, 8'h00, 8'hFF));
        // Threshold zero makes every pixel opaque, even alpha zero.
        set_config(8'h00, 8'h00);
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
        // Threshold 255 leaves only alpha 255 opaque.
        set_config(8'hFF, 8'h5A);
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFE));
        send_item(make_beat(nppq_pkg::OP_QUANT, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF));

        // Random segments. The first two let the sender run and the receiver
        // stall often, the next two the other way round, the last two never
        // idle. Each segment starts with a burst of palette loads and then
        // mixes loads with pixels.
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            case (seg)
                0, 1: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 85;
                end
                2, 3: begin
                    send_idle_pct = 85;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (seg)
                1: begin
                    thr_val  = 8'h00;
                    tidx_val = 8'hFF;
                end
                2: begin
                    thr_val  = 8'hFF;
                    tidx_val = 8'h00;
                end
                3: begin
                    thr_val  = nppq_pkg::OPAQUE_THR_RST;
                    tidx_val = 8'($urandom_range(255));
                end
                default: begin
                    thr_val  = 8'($urandom_range(255));
                    tidx_val = 8'($urandom_range(255));
                end
            endcase
            set_config(thr_val, tidx_val);
            repeat (PALETTE_BURST) send_item(random_beat(100));
            for (int n = 0; n < SEGMENT_BEATS; n++) begin
                if (seg == 0 && n == 100) begin
                    // The receiver holds off for a long stretch while opaque
                    // pixels keep coming, so results back up and the block
                    // has to stall its input.
                    fork
                        begin
                            hold_off <= 1'b1;
                            repeat (HOLD_CYCLES) @(posedge i_clk);
                            hold_off <= 1'b0;
                        end
                    join_none
                    repeat (HOLD_PIXELS)
                        send_item(make_beat(nppq_pkg::OP_QUANT, 8'($urandom_range(255)),
                                            8'($urandom_range(255)), 8'($urandom_range(255)),
                                            8'($urandom_range(255)), 8'hFF));
                end
                // Once, the sender goes quiet until the block has drained.
                if (seg == 2 && n == 150) wait_idle();
                send_item(random_beat(LOAD_PCT));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.expected_indexes.size() != 0)
            tracker.report_mismatch($sformatf("%0d pixel results never arrived",
                                              tracker.expected_indexes.size()));
        if (tracker.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial begin
        #(30_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
